// ----- rtl/bsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the byte-stuffing codec.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ESC_START = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ESC_ESC   = 3'd4;

  localparam logic [BYTE_W-1:0] START_RST     = 8'd115;
  localparam logic [BYTE_W-1:0] ESCAPE_RST    = 8'd120;
  localparam logic [BYTE_W-1:0] ESC_START_RST = 8'd85;
  localparam logic [BYTE_W-1:0] ESC_ESC_RST   = 8'd49;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA       = 2'd0,
    ST_INVALID    = 2'd1,
    ST_START      = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef struct packed {
    logic              unescape_mode;
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] escape_code;
    logic [BYTE_W-1:0] esc_start_code;
    logic [BYTE_W-1:0] esc_esc_code;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_t           status;
    logic              run_last;
    logic              buffer_end;
  } res_t;

endpackage : bsc_pkg
`default_nettype wire

// ----- rtl/bsc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_in_if / bsc_out_if
// Valid/ready request channels of the byte-stuffing codec.
// ----------------------------------------------------------------------------
interface bsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bsc_pkg::BYTE_W-1:0]  data_byte;
  logic                        buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface : bsc_in_if

interface bsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsc_pkg::BYTE_W-1:0]    out_byte;
  logic [bsc_pkg::STATUS_W-1:0]  status;
  logic                          run_last;
  logic                          buffer_end;

  modport source (output valid, output out_byte, output status, output run_last,
                  output buffer_end, input ready);
  modport sink   (input valid, input out_byte, input status, input run_last,
                  input buffer_end, output ready);
endinterface : bsc_out_if
`default_nettype wire

// ----- rtl/bsc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_cfg_regs
// APB register file: mode and the four code bytes.
// ----------------------------------------------------------------------------
module bsc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [bsc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [bsc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready,
  output bsc_pkg::cfg_t                        cfg
);
  import bsc_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MODE:      cfg_nxt.unescape_mode  = cfg_pwdata[0];
        REG_START:     cfg_nxt.start_code     = cfg_pwdata[BYTE_W-1:0];
        REG_ESCAPE:    cfg_nxt.escape_code    = cfg_pwdata[BYTE_W-1:0];
        REG_ESC_START: cfg_nxt.esc_start_code = cfg_pwdata[BYTE_W-1:0];
        REG_ESC_ESC:   cfg_nxt.esc_esc_code   = cfg_pwdata[BYTE_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (idx)
      REG_MODE:      cfg_prdata[0]        = cfg_r.unescape_mode;
      REG_START:     cfg_prdata[BYTE_W-1:0] = cfg_r.start_code;
      REG_ESCAPE:    cfg_prdata[BYTE_W-1:0] = cfg_r.escape_code;
      REG_ESC_START: cfg_prdata[BYTE_W-1:0] = cfg_r.esc_start_code;
      REG_ESC_ESC:   cfg_prdata[BYTE_W-1:0] = cfg_r.esc_esc_code;
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unescape_mode  <= 1'b0;
      cfg_r.start_code     <= START_RST;
      cfg_r.escape_code    <= ESCAPE_RST;
      cfg_r.esc_start_code <= ESC_START_RST;
      cfg_r.esc_esc_code   <= ESC_ESC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule : bsc_cfg_regs
`default_nettype wire

// ----- rtl/byte_stuffing_codec_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffing_codec_core
// Byte-stuffing escape / unescape codec with an APB register port.
//
// in_if  : one buffer byte per request (data_byte, buffer_last).
// out_if : result requests (out_byte, status, run_last, buffer_end).
// cfg_*  : APB registers at 4*i: mode, start, escape, esc_start, esc_esc.
// A request is taken into an input register, decoded in one pass and
// written into a two-entry result holder, which drives out_if. One
// input byte per cycle is sustained while each byte gives one result
// and the receiver is ready; a byte that expands into a pair occupies
// the result holder until both results are taken, so the input stalls
// while the first of the pair is taken. An escape byte in unescape mode
// that opens an escape pair gives no result and leaves the holder free.
// When the receiver stalls, the holder and the input register fill and
// in_if.ready drops; nothing is lost. Reset clears the pending-escape
// flag, both stages and the registers to their default codes.
// ----------------------------------------------------------------------------
module byte_stuffing_codec_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bsc_in_if.sink                               in_if,
  bsc_out_if.source                            out_if,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [bsc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [bsc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);
  import bsc_pkg::*;

  cfg_t              cfg;

  logic              s1_v_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              pend_r;
  logic              pend_nxt;

  res_t              first_r;
  res_t              second_r;
  logic              h_v_r;
  logic              h_two_r;

  res_t              res0;
  res_t              res1;
  logic [1:0]        n_res;
  logic              out_free;
  logic              s1_move;
  logic              in_take;
  logic              out_take;

  bsc_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // decode of the registered byte
  always_comb begin
    res0     = '0;
    res1     = '0;
    n_res    = 2'd0;
    pend_nxt = pend_r;
    if (!cfg.unescape_mode) begin
      pend_nxt = 1'b0;
      priority if (s1_byte_r == cfg.start_code) begin
        res0  = '{cfg.escape_code, ST_DATA, 1'b0, 1'b0};
        res1  = '{cfg.esc_start_code, ST_DATA, 1'b1, s1_last_r};
        n_res = 2'd2;
      end else if (s1_byte_r == cfg.escape_code) begin
        res0  = '{cfg.escape_code, ST_DATA, 1'b0, 1'b0};
        res1  = '{cfg.esc_esc_code, ST_DATA, 1'b1, s1_last_r};
        n_res = 2'd2;
      end else begin
        res0  = '{s1_byte_r, ST_DATA, 1'b1, s1_last_r};
        n_res = 2'd1;
      end
    end else if (pend_r) begin
      pend_nxt = 1'b0;
      n_res    = 2'd1;
      priority if (s1_byte_r == cfg.esc_start_code) begin
        res0 = '{cfg.start_code, ST_DATA, 1'b1, s1_last_r};
      end else if (s1_byte_r == cfg.esc_esc_code) begin
        res0 = '{cfg.escape_code, ST_DATA, 1'b1, s1_last_r};
      end else begin
        res0 = '{'0, ST_INVALID, 1'b1, s1_last_r};
      end
    end else begin
      priority if (s1_byte_r == cfg.escape_code) begin
        if (s1_last_r) begin
          res0  = '{'0, ST_INCOMPLETE, 1'b1, 1'b1};
          n_res = 2'd1;
        end else begin
          pend_nxt = 1'b1;
        end
      end else if (s1_byte_r == cfg.start_code) begin
        res0  = '{'0, ST_START, 1'b1, s1_last_r};
        n_res = 2'd1;
      end else begin
        res0  = '{s1_byte_r, ST_DATA, 1'b1, s1_last_r};
        n_res = 2'd1;
      end
    end
  end

  assign out_take = h_v_r && out_if.ready;
  assign out_free = !h_v_r || (out_if.ready && !h_two_r);
  assign s1_move  = s1_v_r && (out_free || (n_res == 2'd0));
  assign in_take  = in_if.valid && in_if.ready;

  assign in_if.ready       = !s1_v_r || s1_move;
  assign out_if.valid      = h_v_r;
  assign out_if.out_byte   = first_r.out_byte;
  assign out_if.status     = first_r.status;
  assign out_if.run_last   = first_r.run_last;
  assign out_if.buffer_end = first_r.buffer_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      pend_r  <= 1'b0;
      h_v_r   <= 1'b0;
      h_two_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_r    <= 1'b1;
        s1_byte_r <= in_if.data_byte;
        s1_last_r <= in_if.buffer_last;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end

      if (s1_move) begin
        pend_r <= pend_nxt;
      end

      if (s1_move && (n_res != 2'd0)) begin
        h_v_r    <= 1'b1;
        h_two_r  <= (n_res == 2'd2);
        first_r  <= res0;
        second_r <= res1;
      end else if (out_take) begin
        if (h_two_r) begin
          first_r <= second_r;
          h_two_r <= 1'b0;
        end else begin
          h_v_r <= 1'b0;
        end
      end
    end
  end

endmodule : byte_stuffing_codec_core
`default_nettype wire
